### rtl/keypad_alarm_panel_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keypad alarm panel
// Shorthand for clocked checks with a synchronous active-high reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_ALARM_PANEL_CONTROLLER_UNIT_MACROS_SVH
`define KEYPAD_ALARM_PANEL_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define KAP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kap: check failed");

// next-cycle implication
`define KAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kap: check failed");

`endif

### rtl/kap_pkg.sv
// ----------------------------------------------------------------------------
// kap_pkg
// Types, codes and constants shared by the keypad alarm panel modules.
// ----------------------------------------------------------------------------
package kap_pkg;

  localparam int MAX_PIN_DIGITS_DEF   = 8;
  localparam int TICKS_PER_SECOND_DEF = 1000;

  localparam int DELAY_W   = 16;
  localparam int SWEEP_W   = 12;
  localparam int STEP_W    = 8;
  localparam int TONE_W    = 13;
  localparam int SECS_W    = 7;
  localparam int DIGITS_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TONE_W-1:0] TONE_RESET = 13'd500;
  localparam logic [SECS_W-1:0] SECS_MAX   = 7'd127;
  localparam int DEFAULT_PIN_LEN = 4;

  typedef enum logic [2:0] {
    MODE_DISARMED = 3'd0,
    MODE_MENU     = 3'd1,
    MODE_EXIT     = 3'd2,
    MODE_ARMED    = 3'd3,
    MODE_ENTRY    = 3'd4,
    MODE_ALARM    = 3'd5,
    MODE_OLDPIN   = 3'd6,
    MODE_NEWPIN   = 3'd7
  } mode_t;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_KEY    = 2'd1;
  localparam logic [1:0] ACT_MOTION = 2'd2;
  localparam logic [1:0] ACT_SIREN  = 2'd3;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ACCEPTED  = 3'd1;
  localparam logic [2:0] EV_WRONG     = 3'd2;
  localparam logic [2:0] EV_CHANGED   = 3'd3;
  localparam logic [2:0] EV_OLD_WRONG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP  = 3'd4;

  localparam logic [DELAY_W-1:0] EXIT_DELAY_RESET  = 16'd10000;
  localparam logic [DELAY_W-1:0] ENTRY_DELAY_RESET = 16'd30000;
  localparam logic [SWEEP_W-1:0] SWEEP_LOW_RESET   = 12'd500;
  localparam logic [SWEEP_W-1:0] SWEEP_HIGH_RESET  = 12'd1500;
  localparam logic [STEP_W-1:0]  SWEEP_STEP_RESET  = 8'd10;

  typedef struct packed {
    logic [DELAY_W-1:0] exit_delay_ms;
    logic [DELAY_W-1:0] entry_delay_ms;
    logic [SWEEP_W-1:0] sweep_low;
    logic [SWEEP_W-1:0] sweep_high;
    logic [STEP_W-1:0]  sweep_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] key_code;
  } evt_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic                siren_on;
    logic [TONE_W-1:0]   siren_freq;
    logic                led_on;
    logic [SECS_W-1:0]   seconds_left;
    logic [DIGITS_W-1:0] digits_entered;
    logic [2:0]          event_res;
  } res_t;

  // state-update result, still carrying the raw remaining delay in ticks
  typedef struct packed {
    logic [2:0]          mode;
    logic                siren_on;
    logic [TONE_W-1:0]   siren_freq;
    logic                led_on;
    logic [DELAY_W-1:0]  remaining;
    logic [DIGITS_W-1:0] digits_entered;
    logic [2:0]          event_res;
  } stage_t;

  function automatic logic [3:0] default_pin_digit(input int idx);
    default_pin_digit = (idx < DEFAULT_PIN_LEN) ? 4'(idx + 1) : 4'd0;
  endfunction

endpackage

### rtl/kap_chan_if.sv
// ----------------------------------------------------------------------------
// kap_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface kap_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/kap_core.sv
// ----------------------------------------------------------------------------
// kap_core
// Panel state registers and the combinational update for one event word.
// ----------------------------------------------------------------------------
module kap_core #(
  parameter int MAX_PIN_DIGITS = kap_pkg::MAX_PIN_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  kap_pkg::evt_t   evt,
  input  kap_pkg::cfg_t   cfg,
  output kap_pkg::stage_t stage_q
);
  import kap_pkg::*;

  localparam int LEN_W = ($clog2(MAX_PIN_DIGITS + 1) > DIGITS_W) ? DIGITS_W + 1 : DIGITS_W;
  typedef logic [LEN_W-1:0] len_t;
  localparam len_t CAP         = len_t'(MAX_PIN_DIGITS);
  localparam len_t DEFAULT_LEN = len_t'(DEFAULT_PIN_LEN);

  mode_t              mode, mode_next;
  logic [DELAY_W-1:0] elapsed, elapsed_next;
  logic [3:0]         stored [MAX_PIN_DIGITS];
  logic [3:0]         stored_next [MAX_PIN_DIGITS];
  len_t               stored_len, stored_len_next;
  logic [3:0]         entry [MAX_PIN_DIGITS];
  logic [3:0]         entry_next [MAX_PIN_DIGITS];
  len_t               entry_len, entry_len_next;
  logic               entry_ovf, entry_ovf_next;
  logic [TONE_W-1:0]  tone, tone_next;
  logic               sweep_down, sweep_down_next;
  logic               lamp, lamp_next;
  logic [2:0]         ev;
  stage_t             stage_next;

  logic               match;
  logic [DELAY_W-1:0] elapsed_inc;
  logic [TONE_W-1:0]  step_ext, low_ext, high_ext, tone_dn, tone_mv;
  logic [TONE_W:0]    tone_up;
  logic [DELAY_W-1:0] lim;
  logic               is_digit;

  assign is_digit    = evt.key_code <= KEY_DIGIT_MAX;
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;

  assign step_ext = TONE_W'(cfg.sweep_step);
  assign low_ext  = TONE_W'(cfg.sweep_low);
  assign high_ext = TONE_W'(cfg.sweep_high);
  assign tone_dn  = (step_ext > tone) ? '0 : tone - step_ext;
  assign tone_up  = {1'b0, tone} + {1'b0, step_ext};
  assign tone_mv  = sweep_down ? tone_dn : (tone_up[TONE_W] ? '1 : tone_up[TONE_W-1:0]);

  always_comb begin
    match = !entry_ovf && (entry_len == stored_len);
    for (int i = 0; i < MAX_PIN_DIGITS; i++) begin
      if (len_t'(i) < entry_len && entry[i] != stored[i]) match = 1'b0;
    end
  end

  always_comb begin
    mode_next       = mode;
    elapsed_next    = elapsed;
    stored_next     = stored;
    stored_len_next = stored_len;
    entry_next      = entry;
    entry_len_next  = entry_len;
    entry_ovf_next  = entry_ovf;
    tone_next       = tone;
    sweep_down_next = sweep_down;
    lamp_next       = lamp;
    ev              = EV_NONE;

    if (mode == MODE_EXIT && elapsed >= cfg.exit_delay_ms) begin
      mode_next = MODE_ARMED;
    end else if (mode == MODE_ENTRY && elapsed >= cfg.entry_delay_ms) begin
      mode_next      = MODE_ALARM;
      entry_len_next = '0;
      entry_ovf_next = 1'b0;
    end else begin
      case (evt.action)
        ACT_TICK: begin
          if (mode == MODE_EXIT) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cfg.exit_delay_ms) mode_next = MODE_ARMED;
          end else if (mode == MODE_ENTRY) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cfg.entry_delay_ms) begin
              mode_next      = MODE_ALARM;
              entry_len_next = '0;
              entry_ovf_next = 1'b0;
            end
          end
        end
        ACT_KEY: begin
          // a digit key lands in the buffer in every PIN-taking mode, or sets overflow once it is full
          if (is_digit && (mode == MODE_ENTRY || mode == MODE_ALARM ||
                           mode == MODE_OLDPIN || mode == MODE_NEWPIN)) begin
            if (entry_len < CAP) begin
              for (int i = 0; i < MAX_PIN_DIGITS; i++) begin
                if (entry_len == len_t'(i)) entry_next[i] = evt.key_code;
              end
              entry_len_next = entry_len + 1'b1;
            end else begin
              entry_ovf_next = 1'b1;
            end
          end
          unique case (mode)
            MODE_DISARMED: begin
              if (evt.key_code == KEY_STAR) mode_next = MODE_MENU;
            end
            MODE_MENU: begin
              if (evt.key_code == KEY_A) begin
                mode_next    = MODE_EXIT;
                elapsed_next = '0;
              end else if (evt.key_code == KEY_B) begin
                mode_next      = MODE_OLDPIN;
                entry_len_next = '0;
                entry_ovf_next = 1'b0;
              end else if (evt.key_code == KEY_HASH) begin
                mode_next = MODE_DISARMED;
              end
            end
            MODE_ENTRY, MODE_ALARM: begin
              if (evt.key_code == KEY_HASH) begin
                if (match) begin
                  mode_next = MODE_DISARMED;
                  ev        = EV_ACCEPTED;
                end else begin
                  ev = EV_WRONG;
                end
                entry_len_next = '0;
                entry_ovf_next = 1'b0;
              end else if (evt.key_code == KEY_D) begin
                if (!entry_ovf && entry_len != '0) entry_len_next = entry_len - 1'b1;
              end
            end
            MODE_OLDPIN: begin
              if (evt.key_code == KEY_HASH) begin
                if (match) begin
                  mode_next = MODE_NEWPIN;
                end else begin
                  mode_next = MODE_DISARMED;
                  ev        = EV_OLD_WRONG;
                end
                entry_len_next = '0;
                entry_ovf_next = 1'b0;
              end else if (evt.key_code == KEY_D) begin
                mode_next      = MODE_DISARMED;
                entry_len_next = '0;
                entry_ovf_next = 1'b0;
              end
            end
            MODE_NEWPIN: begin
              if (evt.key_code == KEY_HASH || evt.key_code == KEY_D) begin
                if (evt.key_code == KEY_HASH && entry_len != '0 && !entry_ovf) begin
                  // zero the slots past the new length
                  for (int i = 0; i < MAX_PIN_DIGITS; i++) begin
                    stored_next[i] = (len_t'(i) < entry_len) ? entry[i] : 4'd0;
                  end
                  stored_len_next = entry_len;
                  ev              = EV_CHANGED;
                end
                mode_next      = MODE_DISARMED;
                entry_len_next = '0;
                entry_ovf_next = 1'b0;
              end
            end
            MODE_EXIT, MODE_ARMED: ;
          endcase
        end
        ACT_MOTION: begin
          if (mode == MODE_ARMED) begin
            mode_next      = MODE_ENTRY;
            elapsed_next   = '0;
            entry_len_next = '0;
            entry_ovf_next = 1'b0;
          end
        end
        default: begin
          if (mode == MODE_ALARM) begin
            tone_next = tone_mv;
            if (tone_mv > high_ext || tone_mv < low_ext) sweep_down_next = !sweep_down;
            lamp_next = !lamp;
          end
        end
      endcase
    end
  end

  always_comb begin
    lim = (mode_next == MODE_EXIT) ? cfg.exit_delay_ms : cfg.entry_delay_ms;
    stage_next.mode           = mode_next;
    stage_next.siren_on       = (mode_next == MODE_ALARM);
    stage_next.siren_freq     = tone_next;
    stage_next.led_on         = (mode_next == MODE_ALARM) && lamp_next;
    stage_next.digits_entered = entry_len_next[DIGITS_W-1:0];
    stage_next.event_res      = ev;
    if ((mode_next == MODE_EXIT || mode_next == MODE_ENTRY) && elapsed_next < lim) begin
      stage_next.remaining = lim - elapsed_next;
    end else begin
      stage_next.remaining = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_DISARMED;
      elapsed    <= '0;
      stored_len <= DEFAULT_LEN;
      entry_len  <= '0;
      entry_ovf  <= 1'b0;
      tone       <= TONE_RESET;
      sweep_down <= 1'b0;
      lamp       <= 1'b0;
      for (int i = 0; i < MAX_PIN_DIGITS; i++) stored[i] <= default_pin_digit(i);
    end else if (fire) begin
      mode       <= mode_next;
      elapsed    <= elapsed_next;
      stored     <= stored_next;
      stored_len <= stored_len_next;
      entry_len  <= entry_len_next;
      entry_ovf  <= entry_ovf_next;
      tone       <= tone_next;
      sweep_down <= sweep_down_next;
      lamp       <= lamp_next;
    end
  end

  // buffer digits and the result word hold no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      entry   <= entry_next;
      stage_q <= stage_next;
    end
  end

endmodule

### rtl/kap_secs.sv
// ----------------------------------------------------------------------------
// kap_secs
// Result stage: remaining ticks to whole seconds by reciprocal multiply.
// ----------------------------------------------------------------------------
module kap_secs #(
  parameter int TICKS_PER_SECOND = kap_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic            clk,
  input  logic            load,
  input  kap_pkg::stage_t stage,
  output kap_pkg::res_t   res_q
);
  import kap_pkg::*;

  // floor(n/d) = (n*m) >> (W+l) for n < 2^W, l = clog2(d), m = floor(2^(W+l)/d)+1
  localparam int RECIP_SHIFT = DELAY_W + $clog2(TICKS_PER_SECOND);
  localparam int MULT_W      = DELAY_W + 2;
  localparam int PROD_W      = DELAY_W + MULT_W;
  localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) / TICKS_PER_SECOND) + 64'd1;
  localparam logic [MULT_W-1:0] RECIP_MULT = MULT_W'(RECIP_FULL);

  logic [PROD_W-1:0]         prod;
  logic [DELAY_W-1:0]        quot;
  res_t                      res_next;

  assign prod = PROD_W'(stage.remaining) * PROD_W'(RECIP_MULT);
  assign quot = DELAY_W'(prod >> RECIP_SHIFT);

  always_comb begin
    res_next.mode           = stage.mode;
    res_next.siren_on       = stage.siren_on;
    res_next.siren_freq     = stage.siren_freq;
    res_next.led_on         = stage.led_on;
    res_next.digits_entered = stage.digits_entered;
    res_next.event_res      = stage.event_res;
    res_next.seconds_left   = (quot > DELAY_W'(SECS_MAX)) ? SECS_MAX : quot[SECS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res_next;
  end

endmodule

### rtl/keypad_alarm_panel_controller_unit.sv
// ----------------------------------------------------------------------------
// keypad_alarm_panel_controller_unit
// Keypad alarm panel: mode machine, PIN entry and change, siren sweep.
// ----------------------------------------------------------------------------
// Takes one event word per clock while the first stage is free and returns
// one status word per event, in order. The first stage updates the panel
// state (mode, delay count, PIN buffer, tone) in one pass and registers it;
// the second turns the remaining delay into whole seconds with a reciprocal
// multiply and registers the status word. The state-update loop sets the
// rate at one word per cycle; events are taken whenever the first stage is
// empty or can move on, so a held status word stops events only once the
// first stage is full as well. No clearing pass follows reset. Configuration
// words are written on cfg_we and take effect at once.
module keypad_alarm_panel_controller_unit #(
  parameter int MAX_PIN_DIGITS   = kap_pkg::MAX_PIN_DIGITS_DEF,
  parameter int TICKS_PER_SECOND = kap_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  kap_chan_if.sink                       events,
  kap_chan_if.source                     status,
  input  logic                           cfg_we,
  input  logic [kap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kap_pkg::*;

  cfg_t   cfg;
  stage_t stage_q;
  res_t   res_q;
  logic   a_valid, b_valid;
  logic   a_free, b_free, fire, a_move;

  assign b_free = !b_valid || status.ready;
  assign a_free = !a_valid || b_free;
  assign fire   = events.valid && a_free;
  assign a_move = a_valid && b_free;

  assign events.ready = a_free;
  assign status.valid = b_valid;
  assign status.data  = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (fire) a_valid <= 1'b1;
      else if (a_move) a_valid <= 1'b0;
      if (a_move) b_valid <= 1'b1;
      else if (status.ready) b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exit_delay_ms  <= EXIT_DELAY_RESET;
      cfg.entry_delay_ms <= ENTRY_DELAY_RESET;
      cfg.sweep_low      <= SWEEP_LOW_RESET;
      cfg.sweep_high     <= SWEEP_HIGH_RESET;
      cfg.sweep_step     <= SWEEP_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXIT_DELAY:  cfg.exit_delay_ms  <= cfg_data[DELAY_W-1:0];
        CFG_ENTRY_DELAY: cfg.entry_delay_ms <= cfg_data[DELAY_W-1:0];
        CFG_SWEEP_LOW:   cfg.sweep_low      <= cfg_data[SWEEP_W-1:0];
        CFG_SWEEP_HIGH:  cfg.sweep_high     <= cfg_data[SWEEP_W-1:0];
        CFG_SWEEP_STEP:  cfg.sweep_step     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  kap_core #(
    .MAX_PIN_DIGITS (MAX_PIN_DIGITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .evt     (events.data),
    .cfg     (cfg),
    .stage_q (stage_q)
  );

  kap_secs #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_secs (
    .clk   (clk),
    .load  (a_move),
    .stage (stage_q),
    .res_q (res_q)
  );

endmodule

### rtl/kap_checker.sv
// ----------------------------------------------------------------------------
// kap_checker
// Port-level checks on the alarm panel, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_alarm_panel_controller_unit_macros.svh"

module kap_checker (
  input logic          clk,
  input logic          rst,
  input logic          ev_ready,
  input logic          st_valid,
  input logic          st_ready,
  input kap_pkg::res_t st_data
);
  import kap_pkg::*;

  // a held status word stays put
  `KAP_ASSERT_NEXT(a_hold, clk, rst, st_valid && !st_ready, st_valid && $stable(st_data))

  // with no status word waiting, the event side must be open
  `KAP_ASSERT_NOW(a_ready_when_empty, clk, rst, !st_valid, ev_ready)

  `KAP_ASSERT_NOW(a_siren_mode, clk, rst, st_valid,
                  st_data.siren_on == (st_data.mode == MODE_ALARM))

  `KAP_ASSERT_NOW(a_lamp_needs_siren, clk, rst, st_valid && st_data.led_on, st_data.siren_on)

endmodule

bind keypad_alarm_panel_controller_unit kap_checker u_kap_checker (
  .clk      (clk),
  .rst      (rst),
  .ev_ready (events.ready),
  .st_valid (status.valid),
  .st_ready (status.ready),
  .st_data  (status.data)
);

### tb/sv/tb_keypad_alarm_panel_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_keypad_alarm_panel_controller_unit
// Self-checking bench for the alarm panel. A cycle-free model of the panel
// (modes, delay counting, PIN buffer and change, siren sweep) predicts one
// status word per accepted event word. Directed sequences walk every mode and
// corner, then mode-aware random traffic runs under several register settings
// with random idling on both channels and a long status hold-off.
// ----------------------------------------------------------------------------
module tb_keypad_alarm_panel_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kap_pkg::*;

  localparam int MAX_DIGITS     = MAX_PIN_DIGITS_DEF;
  localparam int TICKS_PER_SEC  = TICKS_PER_SECOND_DEF;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_EVENTS   = 130;
  localparam int HOLDOFF_CYCLES = 150;
  localparam logic [3:0] KEY_C = 4'd12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kap_chan_if #(.data_t(evt_t)) evt_ch ();
  kap_chan_if #(.data_t(res_t)) stat_ch ();

  keypad_alarm_panel_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .events    (evt_ch),
    .status    (stat_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Panel model state and its copy of the registers
  logic [DELAY_W-1:0] arm_limit, intrude_limit;
  logic [SWEEP_W-1:0] sweep_lo, sweep_hi;
  logic [STEP_W-1:0]  sweep_inc;
  mode_t              panel_mode;
  logic [DELAY_W-1:0] dwell_ticks;
  logic [3:0]         pin_code [MAX_DIGITS];
  logic [3:0]         pin_len;
  logic [3:0]         keybuf [MAX_DIGITS];
  logic [3:0]         keybuf_len;
  logic               keybuf_over;
  logic [TONE_W-1:0]  tone;
  logic               tone_falling;
  logic               lamp;

  res_t status_q [$];
  int   errors        = 0;
  int   words_checked = 0;
  int   alarm_words   = 0;
  int   events_sent   = 0;
  int   cycle_count   = 0;
  int   ev_tally [8]  = '{default: 0};
  int   gap_odds      = 0;
  int   status_hold   = 0;
  int   holdoff_asks  = 0;
  int   holdoff_taken = 0;
  int   stall_left    = 0;

  function automatic void clear_keybuf();
    keybuf_len  = 0;
    keybuf_over = 1'b0;
  endfunction

  function automatic void panel_reset();
    int i;
    arm_limit     = EXIT_DELAY_RESET;
    intrude_limit = ENTRY_DELAY_RESET;
    sweep_lo      = SWEEP_LOW_RESET;
    sweep_hi      = SWEEP_HIGH_RESET;
    sweep_inc     = SWEEP_STEP_RESET;
    panel_mode    = MODE_DISARMED;
    dwell_ticks   = '0;
    for (i = 0; i < MAX_DIGITS; i++) begin
      pin_code[i] = (i < 4) ? 4'(i + 1) : 4'd0;
      keybuf[i]   = 4'd0;
    end
    pin_len      = 4'd4;
    tone         = TONE_RESET;
    tone_falling = 1'b0;
    lamp         = 1'b0;
    clear_keybuf();
  endfunction

  function automatic void push_digit(logic [3:0] d);
    if (keybuf_len < MAX_DIGITS) begin
      keybuf[keybuf_len] = d;
      keybuf_len++;
    end else begin
      keybuf_over = 1'b1;
    end
  endfunction

  function automatic bit keybuf_matches();
    int i;
    if (keybuf_over || keybuf_len != pin_len) return 1'b0;
    for (i = 0; i < keybuf_len; i++)
      if (keybuf[i] != pin_code[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Leave a delay mode whose count has reached its register
  function automatic bit delay_expired();
    if (panel_mode == MODE_EXIT && dwell_ticks >= arm_limit) begin
      panel_mode = MODE_ARMED;
      return 1'b1;
    end
    if (panel_mode == MODE_ENTRY && dwell_ticks >= intrude_limit) begin
      panel_mode = MODE_ALARM;
      clear_keybuf();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] apply_key(logic [3:0] k);
    logic [2:0] ev;
    int i;
    ev = EV_NONE;
    case (panel_mode)
      MODE_DISARMED: begin
        if (k == KEY_STAR) panel_mode = MODE_MENU;
      end
      MODE_MENU: begin
        if (k == KEY_A) begin
          panel_mode  = MODE_EXIT;
          dwell_ticks = '0;
        end else if (k == KEY_B) begin
          clear_keybuf();
          panel_mode = MODE_OLDPIN;
        end else if (k == KEY_HASH) begin
          panel_mode = MODE_DISARMED;
        end
      end
      MODE_ENTRY, MODE_ALARM: begin
        if (k <= KEY_DIGIT_MAX) begin
          push_digit(k);
        end else if (k == KEY_HASH) begin
          if (keybuf_matches()) begin
            panel_mode = MODE_DISARMED;
            ev = EV_ACCEPTED;
          end else begin
            ev = EV_WRONG;
          end
          clear_keybuf();
        end else if (k == KEY_D) begin
          if (!keybuf_over && keybuf_len > 0) keybuf_len--;
        end
      end
      MODE_OLDPIN: begin
        if (k <= KEY_DIGIT_MAX) begin
          push_digit(k);
        end else if (k == KEY_HASH) begin
          if (keybuf_matches()) begin
            panel_mode = MODE_NEWPIN;
          end else begin
            panel_mode = MODE_DISARMED;
            ev = EV_OLD_WRONG;
          end
          clear_keybuf();
        end else if (k == KEY_D) begin
          panel_mode = MODE_DISARMED;
          clear_keybuf();
        end
      end
      MODE_NEWPIN: begin
        if (k <= KEY_DIGIT_MAX) begin
          push_digit(k);
        end else if (k == KEY_HASH) begin
          if (keybuf_len > 0 && !keybuf_over) begin
            for (i = 0; i < MAX_DIGITS; i++)
              pin_code[i] = (i < keybuf_len) ? keybuf[i] : 4'd0;
            pin_len = keybuf_len;
            ev = EV_CHANGED;
          end
          panel_mode = MODE_DISARMED;
          clear_keybuf();
        end else if (k == KEY_D) begin
          panel_mode = MODE_DISARMED;
          clear_keybuf();
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  // Triangle sweep: floor at zero, saturate at the top of the tone range
  function automatic void sweep_tone();
    int t;
    if (panel_mode != MODE_ALARM) return;
    t = tone;
    if (tone_falling) begin
      t = (sweep_inc > t) ? 0 : t - sweep_inc;
    end else begin
      t = t + sweep_inc;
      if (t > 8191) t = 8191;
    end
    if (t > sweep_hi || t < sweep_lo) tone_falling = !tone_falling;
    tone = 13'(t);
    lamp = !lamp;
  endfunction

  function automatic res_t panel_step(evt_t e);
    res_t       r;
    logic [2:0] ev;
    int         lim;
    int         secs;
    ev   = EV_NONE;
    secs = 0;
    if (!delay_expired()) begin
      case (e.action)
        ACT_TICK: begin
          if (panel_mode == MODE_EXIT || panel_mode == MODE_ENTRY) begin
            if (dwell_ticks != 16'hFFFF) dwell_ticks++;
            void'(delay_expired());
          end
        end
        ACT_KEY: ev = apply_key(e.key_code);
        ACT_MOTION: begin
          if (panel_mode == MODE_ARMED) begin
            panel_mode  = MODE_ENTRY;
            dwell_ticks = '0;
            clear_keybuf();
          end
        end
        default: sweep_tone();
      endcase
    end
    if (panel_mode == MODE_EXIT || panel_mode == MODE_ENTRY) begin
      lim = (panel_mode == MODE_EXIT) ? arm_limit : intrude_limit;
      if (dwell_ticks < lim) secs = (lim - dwell_ticks) / TICKS_PER_SEC;
      if (secs > SECS_MAX) secs = SECS_MAX;
    end
    r.mode           = panel_mode;
    r.siren_on       = (panel_mode == MODE_ALARM);
    r.siren_freq     = tone;
    r.led_on         = (panel_mode == MODE_ALARM) && lamp;
    r.seconds_left   = 7'(secs);
    r.digits_entered = keybuf_len;
    r.event_res      = ev;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Predict on every accepted event word, compare every accepted status word
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst) begin
      if (stat_ch.valid && stat_ch.ready) begin
        got = stat_ch.data;
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t: status word with nothing expected, got mode %0d", $time, got.mode);
        end else begin
          want = status_q.pop_front();
          words_checked++;
          check_field("mode", want.mode, got.mode);
          check_field("siren_on", want.siren_on, got.siren_on);
          check_field("siren_freq", want.siren_freq, got.siren_freq);
          check_field("led_on", want.led_on, got.led_on);
          check_field("seconds_left", want.seconds_left, got.seconds_left);
          check_field("digits_entered", want.digits_entered, got.digits_entered);
          check_field("event_res", want.event_res, got.event_res);
        end
      end
      if (evt_ch.valid && evt_ch.ready) begin
        want = panel_step(evt_ch.data);
        status_q.push_back(want);
        ev_tally[want.event_res]++;
        if (want.mode == MODE_ALARM) alarm_words++;
      end
    end
  end

  // Status receiver: long hold-off on request, otherwise short random stalls
  always @(negedge clk) begin
    if (rst) begin
      stat_ch.ready = 1'b0;
    end else if (holdoff_taken != holdoff_asks) begin
      stat_ch.ready = 1'b0;
      status_hold   = HOLDOFF_CYCLES - 1;
      holdoff_taken++;
    end else if (status_hold > 0) begin
      stat_ch.ready = 1'b0;
      status_hold--;
    end else if (stall_left > 0) begin
      stat_ch.ready = 1'b0;
      stall_left--;
    end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      stat_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      stat_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               status_q.size());
      $display("keypad_alarm_panel_controller_unit verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the accept
  task automatic send_event(logic [1:0] act, logic [3:0] key);
    evt_t w;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      evt_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    w.action     = act;
    w.key_code   = key;
    evt_ch.data  = w;
    evt_ch.valid = 1'b1;
    do @(posedge clk); while (!evt_ch.ready);
    @(negedge clk);
    events_sent++;
  endtask

  task automatic send_key(logic [3:0] k);
    send_event(ACT_KEY, k);
  endtask

  task automatic send_pulse(logic [1:0] act);
    send_event(act, 4'($urandom));
  endtask

  task automatic enter_pin();
    logic [3:0] code [MAX_DIGITS];
    int n;
    int i;
    code = pin_code;
    n    = pin_len;
    for (i = 0; i < n; i++) send_key(code[i]);
    send_key(KEY_HASH);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic settle();
    evt_ch.valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      CFG_EXIT_DELAY:  arm_limit     = val;
      CFG_ENTRY_DELAY: intrude_limit = val;
      CFG_SWEEP_LOW:   sweep_lo      = val[SWEEP_W-1:0];
      CFG_SWEEP_HIGH:  sweep_hi      = val[SWEEP_W-1:0];
      CFG_SWEEP_STEP:  sweep_inc     = val[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper bits of the narrow registers carry junk to exercise the masking
  task automatic write_config(int ex, int en, int lo, int hi, int st);
    write_reg(CFG_EXIT_DELAY, 16'(ex));
    write_reg(CFG_ENTRY_DELAY, 16'(en));
    write_reg(CFG_SWEEP_LOW, {4'($urandom), 12'(lo)});
    write_reg(CFG_SWEEP_HIGH, {4'($urandom), 12'(hi)});
    write_reg(CFG_SWEEP_STEP, {8'($urandom), 8'(st)});
  endtask

  // Mostly the right PIN, with deletes, stray digits and early hashes
  function automatic logic [3:0] pin_attempt_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return KEY_D;
    if (r < 10) return 4'($urandom_range(0, 9));
    if (r < 13) return KEY_HASH;
    if (!keybuf_over && keybuf_len < pin_len) return pin_code[keybuf_len];
    return KEY_HASH;
  endfunction

  function automatic evt_t pick_event();
    evt_t e;
    int   r;
    r = $urandom_range(0, 99);
    e.action   = ACT_KEY;
    e.key_code = 4'($urandom);
    if (r < 8) begin
      e.action = 2'($urandom);
      return e;
    end
    case (panel_mode)
      MODE_DISARMED: begin
        if (r < 80) e.key_code = KEY_STAR;
      end
      MODE_MENU: begin
        if (r < 55) e.key_code = KEY_A;
        else if (r < 80) e.key_code = KEY_B;
        else if (r < 90) e.key_code = KEY_HASH;
      end
      MODE_EXIT: begin
        if (r < 90) e.action = ACT_TICK;
      end
      MODE_ARMED: begin
        if (r < 75) e.action = ACT_MOTION;
      end
      MODE_ENTRY: begin
        if (r < 35) e.action = ACT_TICK;
        else e.key_code = pin_attempt_key();
      end
      MODE_ALARM: begin
        if (r < 55) e.action = ACT_SIREN;
        else e.key_code = pin_attempt_key();
      end
      MODE_NEWPIN: begin
        if (r < 65) e.key_code = 4'($urandom_range(0, 9));
        else if (r < 90) e.key_code = KEY_HASH;
        else if (r < 95) e.key_code = KEY_D;
      end
      default: e.key_code = pin_attempt_key();
    endcase
    return e;
  endfunction

  task automatic test_ignored_events();
    send_key(KEY_C);
    send_key(4'd0);
    send_key(KEY_D);
    send_key(KEY_A);
    send_key(KEY_B);
    send_key(KEY_HASH);
    send_pulse(ACT_MOTION);
    send_pulse(ACT_SIREN);
    send_pulse(ACT_TICK);
  endtask

  // Zero exit delay: the word after A is swallowed by the arming
  task automatic test_arming_sequence();
    settle();
    write_config(0, 2, SWEEP_LOW_RESET, SWEEP_HIGH_RESET, SWEEP_STEP_RESET);
    send_key(KEY_STAR);
    send_key(KEY_HASH);
    send_key(KEY_STAR);
    send_key(KEY_A);
    send_key(4'd9);
    send_pulse(ACT_MOTION);
    send_key(4'd9);
    send_key(4'd0);
    send_key(KEY_D);
    send_pulse(ACT_TICK);
    send_pulse(ACT_TICK);
  endtask

  task automatic test_alarm_keypad();
    int i;
    send_pulse(ACT_SIREN);
    send_pulse(ACT_SIREN);
    for (i = 1; i <= MAX_DIGITS + 1; i++) send_key(4'(i));
    send_key(KEY_D);
    send_key(KEY_HASH);
    enter_pin();
  endtask

  task automatic test_pin_change();
    int i;
    // empty new PIN keeps the old one
    send_key(KEY_STAR);
    send_key(KEY_B);
    enter_pin();
    send_key(KEY_HASH);
    // D cancels from new-PIN entry
    send_key(KEY_STAR);
    send_key(KEY_B);
    enter_pin();
    send_key(4'd3);
    send_key(KEY_D);
    // wrong old PIN
    send_key(KEY_STAR);
    send_key(KEY_B);
    send_key(4'd5);
    send_key(KEY_HASH);
    // D cancels from old-PIN check
    send_key(KEY_STAR);
    send_key(KEY_B);
    send_key(KEY_D);
    // full-length new PIN
    send_key(KEY_STAR);
    send_key(KEY_B);
    enter_pin();
    for (i = 0; i < MAX_DIGITS; i++) send_key(4'($urandom_range(0, 9)));
    send_key(KEY_HASH);
  endtask

  // Lower each delay register while its delay is running
  task automatic test_delay_lowered();
    settle();
    write_config(16'hFFFF, 16'hFFFF, SWEEP_LOW_RESET, SWEEP_HIGH_RESET, SWEEP_STEP_RESET);
    send_key(KEY_STAR);
    send_key(KEY_A);
    send_pulse(ACT_TICK);
    send_pulse(ACT_TICK);
    settle();
    write_reg(CFG_EXIT_DELAY, 16'd1);
    send_pulse(ACT_TICK);
    send_pulse(ACT_MOTION);
    send_key(4'd7);
    send_pulse(ACT_TICK);
    settle();
    write_reg(CFG_ENTRY_DELAY, 16'd0);
    send_key(4'd3);
    send_pulse(ACT_SIREN);
    enter_pin();
  endtask

  task automatic test_siren_sweep();
    settle();
    write_config(0, 0, 100, 4095, 255);
    send_key(KEY_STAR);
    send_key(KEY_A);
    send_key(4'($urandom));
    send_pulse(ACT_MOTION);
    send_pulse(ACT_TICK);
    repeat (36) send_pulse(ACT_SIREN);
    settle();
    write_reg(CFG_SWEEP_STEP, 16'd0);
    repeat (3) send_pulse(ACT_SIREN);
    enter_pin();
    send_pulse(ACT_SIREN);
  endtask

  // Hold status off long enough for the block to back up onto its input
  task automatic test_status_holdoff();
    evt_t e;
    settle();
    gap_odds = 0;
    holdoff_asks++;
    repeat (40) begin
      e = pick_event();
      send_event(e.action, e.key_code);
    end
    settle();
  endtask

  task automatic test_random_traffic();
    evt_t e;
    int   p;
    int   lo;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        write_config(0, 0, 0, 0, 1);
      end else if (p == 1) begin
        write_config(20, 15, 4095, 4095, 255);
      end else begin
        lo = $urandom_range(0, 2000);
        write_config($urandom_range(0, 20), $urandom_range(0, 15), lo,
                     lo + $urandom_range(0, 2095), $urandom_range(1, 255));
      end
      // no idling at all in the closing phase
      if (p == RANDOM_PHASES - 1 || p % 3 == 1) gap_odds = 0;
      else gap_odds = $urandom_range(3, 8);
      repeat (PHASE_EVENTS) begin
        if (panel_mode inside {MODE_ENTRY, MODE_ALARM, MODE_OLDPIN, MODE_NEWPIN} &&
            $urandom_range(0, 29) == 0) begin
          // flood the buffer past its capacity
          repeat (MAX_DIGITS + 1) send_key(4'($urandom_range(0, 9)));
        end else begin
          e = pick_event();
          send_event(e.action, e.key_code);
        end
      end
    end
  endtask

  initial begin
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    evt_ch.valid  = 1'b0;
    evt_ch.data   = '0;
    rst           = 1'b1;
    panel_reset();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    gap_odds = 4;

    test_ignored_events();
    test_arming_sequence();
    test_alarm_keypad();
    test_pin_change();
    test_delay_lowered();
    test_siren_sweep();
    test_status_holdoff();
    test_random_traffic();

    settle();
    $display("%0d events sent, %0d status words checked, %0d of them in alarm",
             events_sent, words_checked, alarm_words);
    $display("PIN accepted %0d, wrong %0d, changed %0d, old PIN wrong %0d",
             ev_tally[EV_ACCEPTED], ev_tally[EV_WRONG], ev_tally[EV_CHANGED],
             ev_tally[EV_OLD_WRONG]);
    if (errors == 0 && status_q.size() == 0) begin
      $display("keypad_alarm_panel_controller_unit verification clean");
    end else begin
      $display("keypad_alarm_panel_controller_unit verification failed");
    end
    $finish;
  end

endmodule
